>>> hw/rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, register codes and saturating fixed-point helpers for the
// Cholesky semidefinite test unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

  typedef logic signed [63:0] val_t;
  typedef logic [63:0]        mag_t;
  typedef logic [127:0]       wide_t;

  localparam val_t VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam val_t VAL_MIN = 64'sh8000_0000_0000_0000;

  localparam int DIM_W     = 12;
  localparam int TOL_W     = 40;
  localparam int TOL_FRAC  = 40;
  localparam int CFG_IDX_W = 2;

  localparam logic [TOL_W-1:0] PIVOT_TOL_RESET   = 40'd110;
  localparam logic [TOL_W-1:0] OFFDIAG_TOL_RESET = 40'd1099512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIMENSION   = 2'd0,
    REG_PIVOT_TOL   = 2'd1,
    REG_OFFDIAG_TOL = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_TESTED    = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_t;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? VAL_MIN : VAL_MAX;
    return s[63:0];
  endfunction

  function automatic val_t sat_sub(input val_t a, input val_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? VAL_MIN : VAL_MAX;
    return s[63:0];
  endfunction

  function automatic mag_t mag64(input val_t a);
    return a[63] ? (~mag_t'(a) + 64'd1) : mag_t'(a);
  endfunction

  // sign a magnitude and clamp; big means the magnitude overflowed 64 bits
  function automatic val_t from_mag(input logic neg, input mag_t m, input logic big);
    if (!neg) return (big || m[63]) ? VAL_MAX : val_t'(m);
    if (big || m > 64'h8000_0000_0000_0000) return VAL_MIN;
    return val_t'(~m + 64'd1);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cst_ram.sv
// ----------------------------------------------------------------------------
// cst_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/cst_mul.sv
// ----------------------------------------------------------------------------
// cst_mul
// 64x64 unsigned multiplier built from four 32x32 partial products, one per
// cycle, accumulated into a 128-bit result. Done pulses on the final add.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_mul
  import cst_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire mag_t  a,
  input  wire mag_t  b,
  output logic       done,
  output wide_t      product
);

  mag_t        ar, br;
  logic [2:0]  phase;
  logic        busy;
  logic [63:0] pp;
  logic [31:0] ah, bh;
  wide_t       addend;

  always_comb begin
    unique case (phase)
      3'd0:    begin ah = ar[31:0];  bh = br[31:0];  end
      3'd1:    begin ah = ar[31:0];  bh = br[63:32]; end
      3'd2:    begin ah = ar[63:32]; bh = br[31:0];  end
      default: begin ah = ar[63:32]; bh = br[63:32]; end
    endcase
    unique case (phase)
      3'd1:      addend = {64'd0, pp};
      3'd2, 3'd3: addend = {32'd0, pp, 32'd0};
      3'd4:      addend = {pp, 64'd0};
      default:   addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= '0;
      end else if (busy) begin
        phase <= phase + 3'd1;
        if (phase == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ar      <= a;
      br      <= b;
      product <= '0;
    end else if (busy) begin
      pp      <= ah * bh;
      product <= product + addend;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cst_div.sv
// ----------------------------------------------------------------------------
// cst_div
// Restoring divider, one quotient bit per cycle over a 128-bit numerator.
// Keeps the low 63 quotient bits and flags any higher set bit as overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_div
  import cst_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire wide_t num,
  input  wire mag_t  den,
  output logic        done,
  output logic [62:0] quot,
  output logic        big
);

  wide_t       nr;
  mag_t        dr;
  logic [63:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] rs;
  logic        ge;

  assign rs = {rem, nr[127]};
  assign ge = rs >= {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 7'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nr   <= num;
      dr   <= den;
      rem  <= '0;
      quot <= '0;
      big  <= 1'b0;
      cnt  <= 7'd127;
    end else if (busy) begin
      nr   <= {nr[126:0], 1'b0};
      rem  <= ge ? 64'(rs - {1'b0, dr}) : rs[63:0];
      quot <= {quot[61:0], ge};
      if (ge && cnt >= 7'd63) begin
        big <= 1'b1;
      end
      cnt <= cnt - 7'd1;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cst_sqrt.sv
// ----------------------------------------------------------------------------
// cst_sqrt
// Digit-by-digit integer square root: floor(sqrt(rad)) of a 128-bit radicand,
// two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_sqrt
  import cst_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire wide_t rad,
  output logic       done,
  output mag_t       root
);

  wide_t       rr;
  logic [65:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [67:0] rs;
  logic [67:0] trial;
  logic        ge;

  assign rs    = {rem, rr[127:126]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rs >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rr   <= rad;
      rem  <= '0;
      root <= '0;
      cnt  <= 6'd63;
    end else if (busy) begin
      rr   <= {rr[125:0], 2'b00};
      rem  <= ge ? 66'(rs - trial) : rs[65:0];
      root <= {root[62:0], ge};
      cnt  <= cnt - 6'd1;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cholesky_semidefinite_test_unit.sv
// ----------------------------------------------------------------------------
// cholesky_semidefinite_test_unit
// Accumulates a symmetric matrix into a dense store and, on evaluate, checks
// positive semidefiniteness by in-place Cholesky factorization.
//
//   channel | signals                                        | dir
//   in      | in_valid/in_ready, command, row_index,         | in
//           | col_index, entry_value                         |
//   out     | out_valid/out_ready, nonconvex, test_status,   | out
//           | index_error                                    |
//   cfg     | cfg_write, cfg_index, cfg_data                 | in
//
// Accumulate: off the diagonal, a read-modify-write of the entry, then of its
// mirror; on it, of the entry alone. Out-of-range entries are not stored.
// Evaluate: a scale scan over the n*n entries, two tolerance products, then
// per column k the pivot and per row below it the column value and, unless
// the pivot is near zero, its quotient. All products use the one multiplier.
// After reset and after every evaluate the store is zeroed, one entry per
// cycle over all MAX_N*MAX_N entries; in_ready stays low meanwhile. A result
// that is not yet taken holds back the next result and its clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cholesky_semidefinite_test_unit
  import cst_pkg::*;
#(
  parameter int MAX_N     = 64,
  parameter int FRAC_BITS = 40
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 command,
  input  wire logic [DIM_W-1:0]     row_index,
  input  wire logic [DIM_W-1:0]     col_index,
  input  wire val_t                 entry_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      nonconvex,
  output logic [1:0]                test_status,
  output logic                      index_error,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TOL_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_N + 1);
  localparam mag_t ONE = 64'd1 << FRAC_BITS;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ACC_RD, S_ACC_WR, S_ACC_RD2, S_ACC_WR2,
    S_SCAN_RD, S_SCAN_GET, S_TOL1, S_TOL1_W, S_TOL2, S_TOL2_W,
    S_DG_RD, S_DG_GET, S_DL_RD, S_DL_GET, S_DL_MUL, S_CHECK, S_SQRT,
    S_COL_RD, S_COL_GET, S_CA_RD, S_CA_GET, S_CB_RD, S_CB_GET, S_C_MUL,
    S_DECIDE, S_DIV, S_NEXT_COL, S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [DIM_W-1:0] dimension;
  logic [TOL_W-1:0] pivot_tol;
  logic [TOL_W-1:0] offdiag_tol;

  // flags and working registers
  logic             entries_seen;
  logic             bad_index_seen;
  logic [DIM_W-1:0] row_r, col_r;
  val_t             val_r;
  logic [AW-1:0]    clr_addr;
  logic [CW-1:0]    n_r, ci, ck, cp;
  val_t             scale, tol, otol, d, dk, v, opa;
  logic             res_nonconvex;
  status_t          res_status;

  // store
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  val_t          ram_wdata, ram_rdata;

  // arithmetic units
  logic  mul_start, mul_done, mul_neg;
  mag_t  mul_a, mul_b;
  wide_t mul_prod;
  logic  div_start, div_done, div_big, div_neg;
  wide_t div_num;
  mag_t  div_den;
  logic [62:0] div_quot;
  logic  sq_start, sq_done;
  wide_t sq_rad;
  mag_t  sq_root;

  wide_t mul_sh, tol_sh;
  val_t  fmul_res, tol_res, div_res, base;
  mag_t  scan_mag;
  val_t  scan_val;
  logic  in_fire, piv_ok, v_over;
  logic  row_bad;

  function automatic logic [AW-1:0] at(input int unsigned r, input int unsigned c);
    return AW'(r * MAX_N + c);
  endfunction

  cst_ram #(.WIDTH(64), .DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cst_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(mul_prod)
  );

  cst_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot), .big(div_big)
  );

  cst_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .rad(sq_rad),
    .done(sq_done), .root(sq_root)
  );

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign mul_sh   = mul_prod >> FRAC_BITS;
  assign fmul_res = from_mag(mul_neg, mul_sh[63:0], |mul_sh[127:64]);
  assign tol_sh   = mul_prod >> TOL_FRAC;
  assign tol_res  = (|tol_sh[127:63]) ? VAL_MAX : val_t'(tol_sh[63:0]);
  assign div_res  = from_mag(div_neg, {1'b0, div_quot}, div_big);
  assign base     = (mag_t'(scale) > ONE) ? scale : val_t'(ONE);
  assign scan_mag = mag64(ram_rdata);
  assign scan_val = scan_mag[63] ? VAL_MAX : val_t'(scan_mag);
  assign piv_ok   = dk > tol;
  assign v_over   = mag64(v) > mag_t'(otol);
  assign row_bad  = (row_index >= dimension) || (col_index >= dimension) ||
                    (32'(row_index) >= MAX_N) || (32'(col_index) >= MAX_N);

  // store read address
  always_comb begin
    unique case (state)
      S_ACC_RD:  ram_raddr = at(row_r, col_r);
      S_ACC_RD2: ram_raddr = at(col_r, row_r);
      S_SCAN_RD: ram_raddr = at(ci, cp);
      S_DG_RD:   ram_raddr = at(ck, ck);
      S_DL_RD:   ram_raddr = at(ck, cp);
      S_COL_RD:  ram_raddr = at(ci, ck);
      S_CA_RD:   ram_raddr = at(ci, cp);
      S_CB_RD:   ram_raddr = at(ck, cp);
      default:   ram_raddr = '0;
    endcase
  end

  // store write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_ACC_WR: begin
        ram_we    = 1'b1;
        ram_waddr = at(row_r, col_r);
        ram_wdata = sat_add(ram_rdata, val_r);
      end
      S_ACC_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = at(col_r, row_r);
        ram_wdata = sat_add(ram_rdata, val_r);
      end
      S_SQRT: begin
        ram_we    = sq_done;
        ram_waddr = at(ck, ck);
        ram_wdata = val_t'(sq_root);
      end
      S_DIV: begin
        ram_we    = div_done;
        ram_waddr = at(ci, ck);
        ram_wdata = div_res;
      end
      S_DECIDE: begin
        // near-zero pivot with a small column value: entry becomes zero
        ram_we    = !piv_ok && !v_over;
        ram_waddr = at(ci, ck);
      end
      default: ram_we = 1'b0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension   <= '0;
      pivot_tol   <= PIVOT_TOL_RESET;
      offdiag_tol <= OFFDIAG_TOL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DIMENSION:   dimension   <= cfg_data[DIM_W-1:0];
        REG_PIVOT_TOL:   pivot_tol   <= cfg_data;
        REG_OFFDIAG_TOL: offdiag_tol <= cfg_data;
        default:         ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      entries_seen   <= 1'b0;
      bad_index_seen <= 1'b0;
      out_valid      <= 1'b0;
      mul_start      <= 1'b0;
      div_start      <= 1'b0;
      sq_start       <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            if (command == CMD_ACCUM) begin
              if (row_bad) begin
                bad_index_seen <= 1'b1;
              end else begin
                row_r        <= row_index;
                col_r        <= col_index;
                val_r        <= entry_value;
                entries_seen <= 1'b1;
                state        <= S_ACC_RD;
              end
            end else begin
              res_nonconvex <= 1'b0;
              if (!entries_seen || dimension == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_FINISH;
              end else if (32'(dimension) > MAX_N) begin
                res_status <= ST_TOO_LARGE;
                state      <= S_FINISH;
              end else begin
                res_status <= ST_TESTED;
                n_r        <= CW'(dimension);
                ci         <= '0;
                cp         <= '0;
                scale      <= '0;
                state      <= S_SCAN_RD;
              end
            end
          end
        end
        S_ACC_RD:  state <= S_ACC_WR;
        S_ACC_WR:  state <= (row_r != col_r) ? S_ACC_RD2 : S_IDLE;
        S_ACC_RD2: state <= S_ACC_WR2;
        S_ACC_WR2: state <= S_IDLE;
        S_SCAN_RD: state <= S_SCAN_GET;
        S_SCAN_GET: begin
          if (scan_val > scale) begin
            scale <= scan_val;
          end
          if (cp == n_r - 1'b1) begin
            cp <= '0;
            if (ci == n_r - 1'b1) begin
              state <= S_TOL1;
            end else begin
              ci    <= ci + 1'b1;
              state <= S_SCAN_RD;
            end
          end else begin
            cp    <= cp + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_TOL1: begin
          mul_a     <= {24'd0, pivot_tol};
          mul_b     <= mag_t'(base);
          mul_start <= 1'b1;
          state     <= S_TOL1_W;
        end
        S_TOL1_W: begin
          if (mul_done) begin
            tol   <= tol_res;
            state <= S_TOL2;
          end
        end
        S_TOL2: begin
          mul_a     <= {24'd0, offdiag_tol};
          mul_b     <= mag_t'(base);
          mul_start <= 1'b1;
          state     <= S_TOL2_W;
        end
        S_TOL2_W: begin
          if (mul_done) begin
            otol  <= tol_res;
            ck    <= '0;
            state <= S_DG_RD;
          end
        end
        S_DG_RD: state <= S_DG_GET;
        S_DG_GET: begin
          d     <= ram_rdata;
          cp    <= '0;
          state <= (ck == '0) ? S_CHECK : S_DL_RD;
        end
        S_DL_RD: state <= S_DL_GET;
        S_DL_GET: begin
          mul_a     <= mag64(ram_rdata);
          mul_b     <= mag64(ram_rdata);
          mul_neg   <= 1'b0;
          mul_start <= 1'b1;
          state     <= S_DL_MUL;
        end
        S_DL_MUL: begin
          if (mul_done) begin
            d     <= sat_sub(d, fmul_res);
            cp    <= cp + 1'b1;
            state <= (cp + 1'b1 == ck) ? S_CHECK : S_DL_RD;
          end
        end
        S_CHECK: begin
          if (d < -tol) begin
            res_nonconvex <= 1'b1;
            state         <= S_FINISH;
          end else begin
            sq_rad   <= {64'd0, (d[63] ? 64'd0 : mag_t'(d))} << FRAC_BITS;
            sq_start <= 1'b1;
            state    <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            dk <= val_t'(sq_root);
            if (ck + 1'b1 == n_r) begin
              state <= S_FINISH;
            end else begin
              ci    <= ck + 1'b1;
              state <= S_COL_RD;
            end
          end
        end
        S_COL_RD: state <= S_COL_GET;
        S_COL_GET: begin
          v     <= ram_rdata;
          cp    <= '0;
          state <= (ck == '0) ? S_DECIDE : S_CA_RD;
        end
        S_CA_RD: state <= S_CA_GET;
        S_CA_GET: begin
          opa   <= ram_rdata;
          state <= S_CB_RD;
        end
        S_CB_RD: state <= S_CB_GET;
        S_CB_GET: begin
          mul_a     <= mag64(opa);
          mul_b     <= mag64(ram_rdata);
          mul_neg   <= opa[63] ^ ram_rdata[63];
          mul_start <= 1'b1;
          state     <= S_C_MUL;
        end
        S_C_MUL: begin
          if (mul_done) begin
            v     <= sat_sub(v, fmul_res);
            cp    <= cp + 1'b1;
            state <= (cp + 1'b1 == ck) ? S_DECIDE : S_CA_RD;
          end
        end
        S_DECIDE: begin
          if (piv_ok) begin
            div_num   <= {64'd0, mag64(v)} << FRAC_BITS;
            div_den   <= mag_t'(dk);
            div_neg   <= v[63];
            div_start <= 1'b1;
            state     <= S_DIV;
          end else if (v_over) begin
            res_nonconvex <= 1'b1;
            state         <= S_FINISH;
          end else if (ci + 1'b1 == n_r) begin
            state <= S_NEXT_COL;
          end else begin
            ci    <= ci + 1'b1;
            state <= S_COL_RD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (ci + 1'b1 == n_r) begin
              state <= S_NEXT_COL;
            end else begin
              ci    <= ci + 1'b1;
              state <= S_COL_RD;
            end
          end
        end
        S_NEXT_COL: begin
          ck    <= ck + 1'b1;
          state <= S_DG_RD;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            nonconvex      <= res_nonconvex;
            test_status    <= res_status;
            index_error    <= bad_index_seen;
            entries_seen   <= 1'b0;
            bad_index_seen <= 1'b0;
            clr_addr       <= '0;
            state          <= S_CLEAR;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> test/cholesky_semidefinite_test_unit_tb.sv
// ----------------------------------------------------------------------------
// cholesky_semidefinite_test_unit_tb
// Self-checking bench: streams entry and evaluate words, predicts each
// evaluate verdict with a bit-exact fixed-point Cholesky model and checks the
// result words in order, under random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cholesky_semidefinite_test_unit_tb
  import cst_pkg::*;
;

  localparam int   MAXN     = 64;
  localparam int   FRACB    = 40;
  localparam int   SETTLE   = 4400;    // clearing pass plus margin
  localparam int   WD_LIMIT = 4000000; // idle limit, well above a full 64x64 factorization
  localparam val_t ONE      = 64'sh100_0000_0000;

  typedef enum logic [1:0] {K_WORD, K_CFG, K_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t       kind;
    logic             cmd;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    val_t             val;
    cfg_reg_t         idx;
    logic [TOL_W-1:0] data;
  } step_t;

  typedef struct {
    logic    nonconvex;
    status_t status;
    logic    index_error;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic command = 1'b0;
  logic [DIM_W-1:0] row_index = '0, col_index = '0;
  val_t entry_value = '0;
  logic out_valid, out_ready = 1'b0;
  logic nonconvex, index_error;
  logic [1:0] test_status;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TOL_W-1:0] cfg_data = '0;

  cholesky_semidefinite_test_unit i_dut (
    .clk, .rst, .in_valid, .in_ready, .command, .row_index, .col_index,
    .entry_value, .out_valid, .out_ready, .nonconvex, .test_status,
    .index_error, .cfg_write, .cfg_index, .cfg_data
  );

  always #10 clk = ~clk;

  step_t    stim_q[$];
  verdict_t verdict_q[$];
  int       err_count = 0;
  int       word_count = 0;

  // predictor state
  val_t             mat [0:MAXN-1][0:MAXN-1];
  logic             seen_entry, seen_bad;
  logic [DIM_W-1:0] p_dim;
  logic [TOL_W-1:0] p_ptol, p_otol;

  // generator-side view of the configuration
  int               g_dim;
  logic [TOL_W-1:0] g_ptol, g_otol;

  // ---------------------------------------------------------------- arithmetic
  function automatic mag_t abs_mag(val_t a);
    return a[63] ? mag_t'(-a) : mag_t'(a);
  endfunction

  function automatic val_t clamp_signed(logic neg, mag_t m, logic big);
    if (!neg) return (big || m[63]) ? VAL_MAX : val_t'(m);
    if (big || m > 64'h8000_0000_0000_0000) return VAL_MIN;
    return val_t'(-m);
  endfunction

  function automatic val_t add_sat(val_t a, val_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return VAL_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return VAL_MIN;
    return s[63:0];
  endfunction

  function automatic val_t sub_sat(val_t a, val_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return VAL_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return VAL_MIN;
    return s[63:0];
  endfunction

  function automatic val_t fx_mul(val_t a, val_t b);
    wide_t p;
    p = (wide_t'(abs_mag(a)) * wide_t'(abs_mag(b))) >> FRACB;
    return clamp_signed(a[63] != b[63], p[63:0], p[127:64] != 0);
  endfunction

  function automatic val_t fx_div(val_t v, val_t d);
    wide_t q;
    q = (wide_t'(abs_mag(v)) << FRACB) / wide_t'(mag_t'(d));
    return clamp_signed(v[63], q[63:0], q[127:63] != 0);
  endfunction

  function automatic val_t fx_sqrt(val_t d);
    wide_t n;
    mag_t  r, t;
    n = wide_t'(mag_t'(d)) << FRACB;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (mag_t'(1) << b);
      if (wide_t'(t) * wide_t'(t) <= n) r = t;
    end
    return val_t'(r);
  endfunction

  function automatic val_t tol_scaled(logic [TOL_W-1:0] frac, val_t base);
    wide_t p;
    p = (wide_t'(frac) * wide_t'(mag_t'(base))) >> TOL_FRAC;
    if (p > wide_t'(VAL_MAX)) return VAL_MAX;
    return val_t'(p[63:0]);
  endfunction

  // in-place factorization of the leading n x n block; 1 on an indefinite finding
  function automatic logic factor_is_indefinite(int n);
    val_t scale, base, tol, otol, d, v, a;
    mag_t m;
    scale = '0;
    for (int i = 0; i < n; i++)
      for (int k = 0; k < n; k++) begin
        m = abs_mag(mat[i][k]);
        a = m[63] ? VAL_MAX : val_t'(m);
        if (a > scale) scale = a;
      end
    base = scale > ONE ? scale : ONE;
    tol  = tol_scaled(p_ptol, base);
    otol = tol_scaled(p_otol, base);
    for (int k = 0; k < n; k++) begin
      d = mat[k][k];
      for (int p = 0; p < k; p++) d = sub_sat(d, fx_mul(mat[k][p], mat[k][p]));
      if (d < -tol) return 1'b1;
      d = fx_sqrt(d > 0 ? d : val_t'(0));
      mat[k][k] = d;
      for (int i = k + 1; i < n; i++) begin
        v = mat[i][k];
        for (int p = 0; p < k; p++) v = sub_sat(v, fx_mul(mat[i][p], mat[k][p]));
        if (d > tol) mat[i][k] = fx_div(v, d);
        else if (abs_mag(v) > mag_t'(otol)) return 1'b1;
        else mat[i][k] = '0;
      end
    end
    return 1'b0;
  endfunction

  task automatic clear_matrix();
    foreach (mat[i, k]) mat[i][k] = '0;
    seen_entry = 1'b0;
    seen_bad   = 1'b0;
  endtask

  // one accepted word into the predictor
  task automatic predict_word(step_t s);
    verdict_t r;
    if (s.cmd == CMD_ACCUM) begin
      if (s.row >= p_dim || s.col >= p_dim || s.row >= MAXN || s.col >= MAXN) begin
        seen_bad = 1'b1;
      end else begin
        mat[s.row][s.col] = add_sat(mat[s.row][s.col], s.val);
        if (s.row != s.col) mat[s.col][s.row] = add_sat(mat[s.col][s.row], s.val);
        seen_entry = 1'b1;
      end
    end else begin
      r.nonconvex = 1'b0;
      if (!seen_entry || p_dim == 0) r.status = ST_EMPTY;
      else if (p_dim > MAXN) r.status = ST_TOO_LARGE;
      else begin
        r.status    = ST_TESTED;
        r.nonconvex = factor_is_indefinite(int'(p_dim));
      end
      r.index_error = seen_bad;
      verdict_q.insert(verdict_q.size(), r);
      clear_matrix();
    end
  endtask

  // ------------------------------------------------------------------ stimulus
  function automatic val_t rand64();
    return val_t'({$urandom, $urandom});
  endfunction

  task automatic push_word(logic cmd, int r, int c, val_t v);
    step_t s;
    s.kind = K_WORD; s.cmd = cmd; s.row = DIM_W'(r); s.col = DIM_W'(c); s.val = v;
    s.idx = REG_DIMENSION; s.data = '0;
    stim_q.insert(stim_q.size(), s);
    word_count++;
  endtask

  task automatic push_eval();
    push_word(CMD_EVAL, $urandom_range(0, 4095), $urandom_range(0, 4095), rand64());
  endtask

  task automatic push_cfg(cfg_reg_t idx, logic [TOL_W-1:0] data);
    step_t s;
    s.kind = K_CFG; s.idx = idx; s.data = data; s.cmd = CMD_ACCUM;
    s.row = '0; s.col = '0; s.val = '0;
    if (idx == REG_DIMENSION) g_dim = int'(data[DIM_W-1:0]);
    else if (idx == REG_PIVOT_TOL) g_ptol = data;
    else g_otol = data;
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic push_drain();
    step_t s;
    s.kind = K_DRAIN; s.cmd = CMD_ACCUM; s.row = '0; s.col = '0; s.val = '0;
    s.idx = REG_DIMENSION; s.data = '0;
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic set_dim(int n);
    // upper bits of the data word are don't-care for the dimension
    push_cfg(REG_DIMENSION,
             40'({$urandom_range(0, 255), 32'(n)} & 40'hFF_FFFF_F000 | 40'(n)));
  endtask

  // one matrix followed by an evaluate; n small (1..6)
  task automatic push_matrix(int style, int n);
    val_t v;
    int   lim;
    lim = g_otol > 40'hFFFF_FFFF ? 32'h7FFF_FFFF : int'(g_otol[31:0]);
    for (int i = 0; i < n; i++)
      for (int j = i; j < n; j++) begin
        case (style)
          0: v = (i == j) ? val_t'(n) * (ONE >>> 2) + val_t'($urandom_range(0, 1 << 30))
                          : val_t'($signed($urandom)) <<< 6;
          1: v = val_t'($signed($urandom)) <<< 10;
          2: begin
            if (i == 0 && j == 0) v = '0;
            else if (i == 0) v = (j == 1) ? val_t'($urandom_range(0, 2 * lim + 2)) : '0;
            else v = (i == j) ? ONE : '0;
            if ($urandom_range(0, 1)) v = -v;
            if (i == 0 && j == 0) v = '0;
            if (i == j && i > 0) v = ONE;
          end
          3: v = (i == 0 && j == 0) ? -val_t'($urandom_range(0, 300))
               : (i == j) ? ONE : '0;
          default: v = rand64();
        endcase
        if (style == 4 && $urandom_range(0, 3) == 0)
          push_word(CMD_ACCUM, $urandom_range(0, 4095), $urandom_range(0, 4095), v);
        else if ($urandom_range(0, 1)) push_word(CMD_ACCUM, i, j, v);
        else push_word(CMD_ACCUM, j, i, v);
      end
    if (style == 4 && $urandom_range(0, 1)) push_word(CMD_ACCUM, n, 0, rand64());
    push_eval();
  endtask

  task automatic build_stimulus();
    int r;
    // directed part
    push_cfg(REG_DIMENSION, 40'd0);
    push_cfg(REG_PIVOT_TOL, PIVOT_TOL_RESET);
    push_cfg(REG_OFFDIAG_TOL, OFFDIAG_TOL_RESET);
    push_word(CMD_ACCUM, 0, 0, ONE);           // dropped: dimension zero
    push_eval();
    push_drain(); set_dim(4);
    push_eval();                               // empty store
    push_word(CMD_ACCUM, 1, 1, '0);            // zero value still counts as entry
    push_eval();
    push_word(CMD_ACCUM, 4095, 4095, VAL_MAX); // out of range only
    push_eval();
    push_word(CMD_ACCUM, 0, 0, VAL_MAX);
    push_word(CMD_ACCUM, 0, 0, VAL_MAX);       // saturates high
    push_word(CMD_ACCUM, 1, 0, VAL_MIN);
    push_word(CMD_ACCUM, 0, 1, VAL_MIN);       // saturates low, mirrored
    push_word(CMD_ACCUM, 3, 3, ONE);
    push_eval();
    push_drain(); set_dim(65);
    push_word(CMD_ACCUM, 2, 2, ONE);
    push_word(CMD_ACCUM, 64, 0, ONE);          // beyond store size
    push_eval();                               // too large
    push_drain(); set_dim(4095);
    push_word(CMD_ACCUM, 5, 7, -ONE);
    push_eval();
    push_drain(); set_dim(64);
    push_word(CMD_ACCUM, 63, 63, ONE);
    push_word(CMD_ACCUM, 0, 0, -ONE);          // early exit at first pivot
    push_eval();
    push_drain(); set_dim(3);
    push_cfg(REG_PIVOT_TOL, '1);
    push_cfg(REG_OFFDIAG_TOL, '0);
    push_matrix(2, 3);
    push_matrix(3, 3);
    // random part
    while (word_count < 600) begin
      push_drain();
      r = $urandom_range(0, 19);
      case (r)
        0: set_dim(0);
        1: set_dim($urandom_range(65, 4095));
        2: set_dim(64);
        default: set_dim($urandom_range(1, 6));
      endcase
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 3);
        push_cfg(REG_PIVOT_TOL, 40'(r == 0 ? 40'd0 : r == 1 ? '1 :
                 r == 2 ? PIVOT_TOL_RESET : {$urandom, $urandom} >> 24));
      end
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 3);
        push_cfg(REG_OFFDIAG_TOL, 40'(r == 0 ? 40'd0 : r == 1 ? '1 :
                 r == 2 ? OFFDIAG_TOL_RESET : {$urandom, $urandom} >> 34));
      end
      repeat ($urandom_range(1, 3)) begin
        if (g_dim == 64) begin
          push_word(CMD_ACCUM, $urandom_range(1, 63), $urandom_range(1, 63), rand64());
          push_word(CMD_ACCUM, 0, 0, -ONE - val_t'($urandom));
          push_eval();
        end else if (g_dim == 0 || g_dim > 64) begin
          repeat ($urandom_range(0, 4))
            push_word(CMD_ACCUM, $urandom_range(0, 70), $urandom_range(0, 70), rand64());
          push_eval();
        end else if ($urandom_range(0, 15) == 0) begin
          push_eval();
        end else begin
          push_matrix($urandom_range(0, 4), g_dim);
        end
      end
    end
  endtask

  // -------------------------------------------------------------------- driver
  int   gap_cnt = 0, settle_cnt = 0;
  logic in_burst = 1'b0;

  function automatic int draw_wait();
    if ($urandom_range(0, 39) == 0) in_burst = ~in_burst;
    return in_burst ? 0 : $urandom_range(0, 6);
  endfunction

  always @(posedge clk) begin : drive
    logic  busy, nxt_we;
    step_t s;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      busy   = in_valid;
      nxt_we = 1'b0;
      if (in_valid && in_ready) begin
        s.kind = K_WORD; s.cmd = command; s.row = row_index; s.col = col_index;
        s.val = entry_value; s.idx = REG_DIMENSION; s.data = '0;
        predict_word(s);
        busy    = 1'b0;
        gap_cnt = draw_wait();
      end
      if (!busy && stim_q.size() != 0) begin
        s = stim_q[0];
        case (s.kind)
          K_DRAIN: begin
            settle_cnt = verdict_q.size() == 0 ? settle_cnt + 1 : 0;
            if (settle_cnt >= SETTLE) begin
              void'(stim_q.pop_front());
              settle_cnt = 0;
            end
          end
          K_CFG: begin
            nxt_we = 1'b1;
            cfg_index <= s.idx;
            cfg_data  <= s.data;
            if (s.idx == REG_DIMENSION) p_dim = s.data[DIM_W-1:0];
            else if (s.idx == REG_PIVOT_TOL) p_ptol = s.data;
            else p_otol = s.data;
            void'(stim_q.pop_front());
          end
          default: begin
            if (gap_cnt > 0) gap_cnt--;
            else begin
              busy = 1'b1;
              command     <= s.cmd;
              row_index   <= s.row;
              col_index   <= s.col;
              entry_value <= s.val;
              void'(stim_q.pop_front());
            end
          end
        endcase
      end
      in_valid  <= busy;
      cfg_write <= nxt_we;
    end
  end

  // ------------------------------------------------------------------- monitor
  int stall_cnt = 0;

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : observe
    verdict_t e;
    logic     rdy;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rdy = out_ready;
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report("unexpected result word", 1, 0);
        end else begin
          e = verdict_q.pop_front();
          if (nonconvex !== e.nonconvex) report("nonconvex", nonconvex, e.nonconvex);
          if (test_status !== e.status) report("test_status", test_status, e.status);
          if (index_error !== e.index_error)
            report("index_error", index_error, e.index_error);
        end
        stall_cnt = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
        rdy = stall_cnt == 0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        rdy = stall_cnt == 0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  // ------------------------------------------------------------------ watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= WD_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    p_dim  = '0;
    p_ptol = PIVOT_TOL_RESET;
    p_otol = OFFDIAG_TOL_RESET;
    g_dim  = 0;
    g_ptol = PIVOT_TOL_RESET;
    g_otol = OFFDIAG_TOL_RESET;
    clear_matrix();
    build_stimulus();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (stim_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
